FILE: hdl/quoted_list_field_parser_macros.svh
// Assertion helpers for the checker file.
`ifndef QUOTED_LIST_FIELD_PARSER_MACROS_SVH
`define QUOTED_LIST_FIELD_PARSER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define QLFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define QLFP_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/qlfp_pkg.sv
`default_nettype none
package qlfp_pkg;

  localparam int HELD_BLANK_DEPTH = 32;
  localparam int HELD_CNT_W = $clog2(HELD_BLANK_DEPTH + 1);
  localparam int HELD_IDX_W = (HELD_BLANK_DEPTH > 1) ? $clog2(HELD_BLANK_DEPTH) : 1;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_LAST = 2'd2;

  // Raw terminator to swallow after an escaped line break.
  localparam logic [1:0] TERM_NONE    = 2'd0;
  localparam logic [1:0] TERM_SKIP_CR = 2'd1;
  localparam logic [1:0] TERM_SKIP_LF = 2'd2;

  // Final action of one transaction, after any flush of held blanks.
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_CHAR = 3'd1;
  localparam logic [2:0] OP_END  = 3'd2;
  localparam logic [2:0] OP_LAST = 3'd3;
  localparam logic [2:0] OP_PUSH = 3'd4;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } esc_t;

  typedef struct packed {
    logic push;
    logic push_tab;
    logic pop;
    logic clear;
  } held_cmd_t;

  typedef struct packed {
    logic [HELD_CNT_W-1:0] count;
    logic                  full;
    logic                  head_tab;
  } held_stat_t;

  function automatic esc_t esc_lookup(input logic [7:0] b);
    esc_t r;
    r.hit = 1'b1;
    r.ch  = b;
    case (b)
      8'h61:   r.ch = 8'h07;  // a
      8'h62:   r.ch = 8'h08;  // b
      8'h66:   r.ch = 8'h0C;  // f
      8'h6E:   r.ch = 8'h0A;  // n
      8'h72:   r.ch = 8'h0D;  // r
      8'h74:   r.ch = 8'h09;  // t
      8'h76:   r.ch = 8'h0B;  // v
      8'h22:   r.ch = 8'h22;
      8'h3F:   r.ch = 8'h3F;
      8'h27:   r.ch = 8'h27;
      8'h5C:   r.ch = 8'h5C;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/quoted_list_field_parser.sv
`default_nettype none
// Channel   Dir  tdata                tuser                tlast
// s_axis    in   [7:0] text_byte      [0] action           -
// m_axis    out  [7:0] field_char     [1:0] kind           last
//
// A transaction is accepted, then the sequencer emits its results in turn; one
// with no final character or mark passes the sequencer without emitting.
// A character that follows held blanks is emitted after those blanks.
// Reset clears all parser flags and the held-blank count at once.
// An output stall holds the sequencer while it has a result to emit; the input is
// taken only while idle, even if a finished result still waits in the output register.
module quoted_list_field_parser
  import qlfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] text_byte
  input  wire logic       s_axis_tuser_i,   // [0] action
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] field_char
  output logic [1:0]      m_axis_tuser_o,   // [1:0] kind
  output logic            m_axis_tlast_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic       state_q, state_d;
  logic       inq_q, inq_d;
  logic       quoted_q, quoted_d;
  logic       esc_q, esc_d;
  logic [1:0] term_q, term_d;
  logic       skip_q, skip_d;
  logic [2:0] op_q, op_d;
  logic       flush_q, flush_d;
  logic [7:0] ch_q, ch_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic [1:0] out_kind_q, out_kind_d;
  logic       out_last_q, out_last_d;

  held_cmd_t  held_cmd;
  held_stat_t held_stat;

  logic       accept;
  logic       can_put;
  esc_t       esc;
  logic [7:0] b;
  logic       blank_in;
  logic       term_hit;
  logic [7:0] blank_char;

  qlfp_held_buf u_held (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (held_cmd),
    .stat_o (held_stat)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign can_put         = !out_valid_q || m_axis_tready_i;
  assign b               = s_axis_tdata_i;
  assign esc             = esc_lookup(b);
  assign blank_in        = (b == CH_SPACE) || (b == CH_TAB);
  assign term_hit        = ((term_q == TERM_SKIP_CR) && (b == CH_CR)) ||
                           ((term_q == TERM_SKIP_LF) && (b == CH_LF));
  assign blank_char      = held_stat.head_tab ? CH_TAB : CH_SPACE;

  // Decode of an accepted byte: parser flags update at once, and the
  // emitting part is left to the sequencer as an operation code.
  always_comb begin
    inq_d    = inq_q;
    quoted_d = quoted_q;
    esc_d    = esc_q;
    term_d   = term_q;
    skip_d   = skip_q;
    op_d     = op_q;
    flush_d  = flush_q;
    ch_d     = ch_q;
    if (accept) begin
      op_d    = OP_NONE;
      flush_d = 1'b0;
      ch_d    = b;
      if (s_axis_tuser_i) begin
        op_d     = OP_LAST;
        inq_d    = 1'b0;
        quoted_d = 1'b0;
        esc_d    = 1'b0;
        term_d   = TERM_NONE;
        skip_d   = 1'b0;
      end else if (esc_q) begin
        esc_d = 1'b0;
        ch_d  = esc.ch;
        if (esc.hit) begin
          // Only the escaped t maps onto a blank.
          if (!quoted_q && (esc.ch == CH_TAB)) begin
            op_d = OP_PUSH;
          end else begin
            op_d    = OP_CHAR;
            flush_d = 1'b1;
          end
        end
        if (b == CH_LF) begin
          term_d = TERM_SKIP_CR;
        end else if (b == CH_CR) begin
          term_d = TERM_SKIP_LF;
        end
      end else begin
        term_d = TERM_NONE;
        if (!term_hit && !(skip_q && blank_in)) begin
          skip_d = 1'b0;
          if (b == CH_BSL) begin
            esc_d = 1'b1;
          end else if (b == CH_QUOTE) begin
            flush_d  = 1'b1;
            quoted_d = 1'b1;
            inq_d    = !inq_q;
            skip_d   = inq_q;
          end else if ((b == CH_COMMA) && !inq_q) begin
            op_d     = OP_END;
            quoted_d = 1'b0;
            skip_d   = 1'b1;
          end else if (!quoted_q && blank_in) begin
            op_d = OP_PUSH;
          end else begin
            op_d    = OP_CHAR;
            flush_d = 1'b1;
          end
        end
      end
    end
  end

  // Sequencer: drains held blanks one per cycle when flushed and not stalled, then runs the final action.
  always_comb begin
    state_d     = state_q;
    held_cmd    = '0;
    held_cmd.push_tab = (ch_q == CH_TAB);
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (accept) begin
      state_d = ST_EMIT;
    end else if (state_q == ST_EMIT) begin
      if (flush_q && (held_stat.count != '0)) begin
        if (can_put) begin
          held_cmd.pop = 1'b1;
          out_valid_d  = 1'b1;
          out_kind_d   = KIND_CHAR;
          out_char_d   = blank_char;
          out_last_d   = (held_stat.count == HELD_CNT_W'(1)) && (op_q == OP_NONE);
        end
      end else begin
        case (op_q)
          OP_CHAR: begin
            if (can_put) begin
              out_valid_d = 1'b1;
              out_kind_d  = KIND_CHAR;
              out_char_d  = ch_q;
              out_last_d  = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          OP_END, OP_LAST: begin
            if (can_put) begin
              held_cmd.clear = 1'b1;
              out_valid_d    = 1'b1;
              out_kind_d     = (op_q == OP_END) ? KIND_END : KIND_LAST;
              out_char_d     = '0;
              out_last_d     = 1'b1;
              state_d        = ST_IDLE;
            end
          end
          OP_PUSH: begin
            if (held_stat.full) begin
              // A full line gives up its oldest blank to make room.
              if (can_put) begin
                held_cmd.pop  = 1'b1;
                held_cmd.push = 1'b1;
                out_valid_d   = 1'b1;
                out_kind_d    = KIND_CHAR;
                out_char_d    = blank_char;
                out_last_d    = 1'b1;
                state_d       = ST_IDLE;
              end
            end else begin
              held_cmd.push = 1'b1;
              state_d       = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inq_q       <= 1'b0;
      quoted_q    <= 1'b0;
      esc_q       <= 1'b0;
      term_q      <= TERM_NONE;
      skip_q      <= 1'b0;
      op_q        <= OP_NONE;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inq_q       <= inq_d;
      quoted_q    <= quoted_d;
      esc_q       <= esc_d;
      term_q      <= term_d;
      skip_q      <= skip_d;
      op_q        <= op_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    out_char_q <= out_char_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
`default_nettype wire

FILE: hdl/qlfp_held_buf.sv
`default_nettype none
module qlfp_held_buf
  import qlfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire held_cmd_t cmd_i,
  output held_stat_t stat_o
);

  logic [HELD_BLANK_DEPTH-1:0] tabs_q, tabs_d;
  logic [HELD_CNT_W-1:0]       count_q, count_d;
  logic [HELD_CNT_W-1:0]       cnt_popped;

  // The oldest blank sits in bit 0; a pop shifts the line down by one.
  always_comb begin
    tabs_d     = tabs_q;
    cnt_popped = count_q;
    if (cmd_i.pop) begin
      tabs_d     = tabs_q >> 1;
      cnt_popped = count_q - HELD_CNT_W'(1);
    end
    count_d = cnt_popped;
    if (cmd_i.push) begin
      tabs_d[cnt_popped[HELD_IDX_W-1:0]] = cmd_i.push_tab;
      count_d = cnt_popped + HELD_CNT_W'(1);
    end
    if (cmd_i.clear) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tabs_q <= tabs_d;
  end

  assign stat_o.count    = count_q;
  assign stat_o.full     = (count_q == HELD_CNT_W'(HELD_BLANK_DEPTH));
  assign stat_o.head_tab = tabs_q[0];

endmodule
`default_nettype wire

FILE: hdl/qlfp_checker.sv
`default_nettype none
`include "quoted_list_field_parser_macros.svh"
module qlfp_checker
  import qlfp_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       s_axis_tuser_i,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic [1:0] m_axis_tuser_o,
  input wire logic       m_axis_tlast_o
);

  `QLFP_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "stalled result changed")
  `QLFP_NEVER(a_kind_code, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o != KIND_CHAR) && (m_axis_tuser_o != KIND_END) && (m_axis_tuser_o != KIND_LAST), "undefined result kind")
  `QLFP_ASSERT(a_mark_last, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o != KIND_CHAR) |-> m_axis_tlast_o && (m_axis_tdata_o == 8'd0), "field mark not final or carries data")
  `QLFP_ASSERT(a_busy_after, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "second transaction taken while busy")
  `QLFP_ASSERT(a_end_marks, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i |=> ##1 m_axis_tvalid_o, "end of text gave no mark")

endmodule

bind quoted_list_field_parser qlfp_checker u_qlfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import qlfp_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } field_out_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;   // [7:0] text_byte
  logic       s_axis_tuser_i = 1'b0;    // [0] action
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;           // [7:0] field_char
  logic [1:0] m_axis_tuser_o;           // [1:0] kind
  logic       m_axis_tlast_o;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Parser state as the scoreboard sees it.
  logic       in_quotes = 1'b0;
  logic       field_quoted = 1'b0;
  logic       esc_pending = 1'b0;
  logic [1:0] term_skip = TERM_NONE;
  logic       skip_blanks = 1'b0;
  bit         blank_tab [HELD_BLANK_DEPTH];
  int         blank_cnt = 0;

  field_out_t  field_q[$];
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned sink_hold = 0;
  int unsigned n_sent = 0;
  int unsigned n_fail = 0;

  quoted_list_field_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void emit(logic [1:0] kind, logic [7:0] ch);
    field_out_t r;
    r.kind = kind;
    r.ch   = ch;
    r.last = 1'b0;
    field_q.push_back(r);
  endfunction

  function automatic void flush_blanks();
    for (int k = 0; k < blank_cnt; k++) emit(KIND_CHAR, blank_tab[k] ? CH_TAB : CH_SPACE);
    blank_cnt = 0;
  endfunction

  function automatic void add_field_char(logic [7:0] c);
    if (!field_quoted && (c == CH_SPACE || c == CH_TAB)) begin
      // A full hold buffer releases its oldest blank to make room.
      if (blank_cnt >= HELD_BLANK_DEPTH) begin
        emit(KIND_CHAR, blank_tab[0] ? CH_TAB : CH_SPACE);
        for (int k = 0; k < HELD_BLANK_DEPTH - 1; k++) blank_tab[k] = blank_tab[k + 1];
        blank_cnt = HELD_BLANK_DEPTH - 1;
      end
      blank_tab[blank_cnt] = (c == CH_TAB);
      blank_cnt++;
    end else begin
      flush_blanks();
      emit(KIND_CHAR, c);
    end
  endfunction

  function automatic bit unescape(input logic [7:0] b, output logic [7:0] c);
    unescape = 1'b1;
    c = b;
    case (b)
      "a":     c = 8'h07;
      "b":     c = 8'h08;
      "f":     c = 8'h0C;
      "n":     c = CH_LF;
      "r":     c = CH_CR;
      "t":     c = CH_TAB;
      "v":     c = 8'h0B;
      CH_QUOTE, "?", "'", CH_BSL: c = b;
      default: unescape = 1'b0;
    endcase
  endfunction

  function automatic void predict_fields(logic act, logic [7:0] b);
    logic [7:0] c;
    logic [1:0] t;
    logic       swallow;
    int         before_n;
    field_out_t tail;
    before_n = field_q.size();
    if (act == ACT_END) begin
      emit(KIND_LAST, 8'h00);
      in_quotes    = 1'b0;
      field_quoted = 1'b0;
      esc_pending  = 1'b0;
      term_skip    = TERM_NONE;
      skip_blanks  = 1'b0;
      blank_cnt    = 0;
    end else if (esc_pending) begin
      esc_pending = 1'b0;
      if (unescape(b, c)) add_field_char(c);
      if (b == CH_LF) term_skip = TERM_SKIP_CR;
      else if (b == CH_CR) term_skip = TERM_SKIP_LF;
    end else begin
      t = term_skip;
      term_skip = TERM_NONE;
      swallow = (t == TERM_SKIP_CR && b == CH_CR) || (t == TERM_SKIP_LF && b == CH_LF);
      if (!swallow && skip_blanks && (b == CH_SPACE || b == CH_TAB)) swallow = 1'b1;
      if (!swallow) begin
        skip_blanks = 1'b0;
        if (b == CH_BSL) begin
          esc_pending = 1'b1;
        end else if (b == CH_QUOTE) begin
          flush_blanks();
          field_quoted = 1'b1;
          in_quotes = !in_quotes;
          if (!in_quotes) skip_blanks = 1'b1;
        end else if (b == CH_COMMA && !in_quotes) begin
          blank_cnt = 0;
          emit(KIND_END, 8'h00);
          field_quoted = 1'b0;
          skip_blanks = 1'b1;
        end else begin
          add_field_char(b);
        end
      end
    end
    if (field_q.size() > before_n) begin
      tail = field_q.pop_back();
      tail.last = 1'b1;
      field_q.push_back(tail);
    end
  endfunction

  task automatic send_text(logic act, logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_fields(act, b);
    n_sent++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_text(ACT_BYTE, s[i]);
  endtask

  task automatic end_text();
    send_text(ACT_END, 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (field_q.size() != 0);
  endtask

  function automatic logic [7:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return 8'($urandom_range(8'h7A, 8'h61));
    if (r < 45) return $urandom_range(1) ? CH_TAB : CH_SPACE;
    if (r < 55) return CH_COMMA;
    if (r < 63) return CH_QUOTE;
    if (r < 73) return CH_BSL;
    if (r < 80) return $urandom_range(1) ? CH_CR : CH_LF;
    return 8'($urandom_range(255));
  endfunction

  // Random text, mostly well formed, that may hold further ends and is closed by an end.
  task automatic send_record(int unsigned n_bytes);
    int unsigned n_run;
    for (int unsigned k = 0; k < n_bytes; k++) begin
      if ($urandom_range(99) < 4) begin
        n_run = $urandom_range(40, 20);
        repeat (n_run) send_text(ACT_BYTE, $urandom_range(1) ? CH_TAB : CH_SPACE);
      end else if ($urandom_range(99) < 3) begin
        end_text();
      end else if ($urandom_range(99) < 10) begin
        send_text(ACT_BYTE, 8'($urandom_range(255)));
      end else begin
        send_text(ACT_BYTE, pick_text_byte());
      end
    end
    end_text();
  endtask

  task automatic test_plain_fields();
    end_text();
    send_text(ACT_BYTE, 8'h00);
    send_text(ACT_BYTE, 8'hFF);
    send_string(" a\t ,");
    send_string("\"x,y\"  z,ab  \"c\"");
    end_text();
    send_string("\"open");
    end_text();
  endtask

  task automatic test_escapes();
    send_string("\\a\\b\\f\\n\\r\\t\\v\\\"\\?\\'\\\\\\q");
    // An escaped tab is held like a raw one: flushed before the next character, dropped at the end.
    send_string("\\t x\\t");
    end_text();
    send_string("\\");
    send_text(ACT_BYTE, CH_CR);
    send_text(ACT_BYTE, CH_LF);
    send_string("\\");
    send_text(ACT_BYTE, CH_LF);
    send_text(ACT_BYTE, CH_CR);
    send_text(ACT_BYTE, CH_CR);
    send_string("\\");
    end_text();
  endtask

  task automatic test_held_overflow();
    send_string("q");
    repeat (HELD_BLANK_DEPTH + 3) send_text(ACT_BYTE, $urandom_range(1) ? CH_TAB : CH_SPACE);
    send_string("r");
    repeat (HELD_BLANK_DEPTH) send_text(ACT_BYTE, $urandom_range(1) ? CH_TAB : CH_SPACE);
    send_string("s");
    end_text();
  endtask

  task automatic test_output_stall();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    sink_hold     = 300;
    send_record(40);
    wait_drained();
  endtask

  task automatic test_paused_source();
    send_record(20);
    wait_drained();
    send_record(20);
  endtask

  task automatic test_random_traffic(int unsigned src_pct, int unsigned sink_pct,
                                     int unsigned n_items);
    int unsigned start;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    start = n_sent;
    while (n_sent - start < n_items) send_record($urandom_range(24, 1));
  endtask

  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      m_axis_tready_i <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    field_out_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (field_q.size() == 0) begin
        $error("unexpected transaction: kind %0d, field_char 0x%02h, last %0b",
               m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
        n_fail++;
      end else begin
        want = field_q.pop_front();
        if (m_axis_tuser_o !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser_o);
          n_fail++;
        end
        if (m_axis_tdata_o !== want.ch) begin
          $error("field_char: expected 0x%02h, actual 0x%02h", want.ch, m_axis_tdata_o);
          n_fail++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, m_axis_tlast_o);
          n_fail++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_fields();
    test_escapes();
    test_held_overflow();
    test_output_stall();
    test_paused_source();
    test_random_traffic(15, 59, 50);
    test_random_traffic(59, 15, 50);
    test_random_traffic(0, 0, 50);
    wait_drained();
    // Let any unexpected late transaction show up before the verdict.
    repeat (40) @(posedge clk_i);
    if (n_fail == 0 && field_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/qlfp_pkg.sv
hdl/qlfp_held_buf.sv
hdl/quoted_list_field_parser.sv
hdl/qlfp_checker.sv
tb/sv/testbench.sv
